[sv/kci_pkg.sv]
`timescale 1ns / 1ps

package kci_pkg;

    // Configuration register map.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BASE  = 3'd1;
    localparam int KEY_COUNT_W = 3;

    // Keyframe word layout, as offsets above the time field's top bit.
    localparam int COLOR_W   = 8;
    localparam int INTEN_W   = 16;
    localparam int RED_OFS   = 1;
    localparam int GRN_OFS   = 9;
    localparam int BLU_OFS   = 17;
    localparam int INT_OFS   = 25;
    localparam int KEY_EXTRA = 41;

    // Result word layout.
    localparam int OUT_W = 3 * COLOR_W + INTEN_W;

    // Per-cycle control of the serial blend units.
    typedef struct packed {
        logic load;  // capture endpoints, clear accumulator
        logic step;  // consume one fraction bit
        logic last;  // the step for the integer bit of the fraction
        logic ubit;  // the fraction bit itself
    } t_lerp_ctl;

endpackage

[sv/kci_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, most significant bit first.
// Forms floor(num * 2^TIME_BITS / den) for num <= den; a zero divisor gives 0.
module kci_div #(
    parameter int TIME_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [TIME_BITS:0]   i_num,
    input  logic [TIME_BITS:0]   i_den,
    output logic                 o_done,
    output logic [TIME_BITS:0]   o_quot
);

    localparam int CNT_W = $clog2(TIME_BITS + 2);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(TIME_BITS + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [TIME_BITS:0]   r_rem;
    logic [TIME_BITS:0]   r_den;
    logic [TIME_BITS:0]   r_quot;
    logic                 r_zero;

    logic [TIME_BITS+1:0] w_trial;
    logic [TIME_BITS+1:0] w_diff;
    logic                 w_ge;

    // The first step tests the integer bit, so the remainder is not doubled.
    assign w_trial = (r_cnt == STEPS) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_zero <= (i_den == '0);
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? w_diff[TIME_BITS:0] : w_trial[TIME_BITS:0];
            r_quot <= {r_quot[TIME_BITS-1:0], w_ge};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_zero ? '0 : r_quot;

endmodule

[sv/kci_lerp.sv]
`timescale 1ns / 1ps

// Serial blend of one channel: a + floor((b - a) * u / 2^TIME_BITS), taking the
// fraction u one bit per cycle while step is set, least significant bit first.
module kci_lerp
    import kci_pkg::*;
#(
    parameter int W = 8
) (
    input  logic          i_clk,
    input  t_lerp_ctl     i_ctl,
    input  logic [W-1:0]  i_a,
    input  logic [W-1:0]  i_b,
    output logic [W-1:0]  o_val
);

    logic        [W-1:0] r_a;
    logic signed [W:0]   r_d;
    logic signed [W+1:0] r_acc;

    logic signed [W+1:0] w_sum;
    logic signed [W+1:0] w_res;

    assign w_sum = r_acc + (i_ctl.ubit ? {r_d[W], r_d} : '0);
    assign w_res = $signed({2'b00, r_a}) + r_acc;
    assign o_val = w_res[W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a   <= i_a;
            r_d   <= $signed({1'b0, i_b}) - $signed({1'b0, i_a});
            r_acc <= '0;
        end else if (i_ctl.step) begin
            // The integer bit of u is the only one not followed by a halving.
            r_acc <= i_ctl.last ? w_sum : (w_sum >>> 1);
        end
    end

endmodule

[sv/keyframe_color_interpolator_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   time_of_day
// m_axis    out        m_axis_tvalid/m_axis_tready   red, green, blue, intensity
// cfg       in         i_cfg_valid/o_cfg_ready       register index, write data
//
// An item for which no keyframe pair encloses the time is done after the scan of
// the n keyframes in use, one pair examined per cycle. When the k-th pair does
// enclose it, the scan stops there and the serial divider (TIME_BITS + 1 steps,
// then done) and the serial blend (TIME_BITS + 1 steps) follow the scan.
// Reset is synchronous and active low; it leaves one keyframe in use with all
// keyframe words zero. A stalled result waits in the output register while the
// next item is taken.
module keyframe_color_interpolator_core
    import kci_pkg::*;
#(
    parameter int MAX_KEYS  = 7,
    parameter int TIME_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: time_of_day [TIME_BITS-1:0], upper bits zero
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((TIME_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // tdata: red [7:0], green [15:8], blue [23:16], intensity [39:24]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [OUT_W-1:0]                     m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_index,
    input  logic [TIME_BITS+KEY_EXTRA-1:0]       i_cfg_data
);

    localparam int KW    = TIME_BITS + KEY_EXTRA;
    localparam int KA_W  = $clog2(MAX_KEYS);
    localparam int IDX_W = $clog2(MAX_KEYS + 1);
    localparam int CNT_W = $clog2(TIME_BITS + 1);
    localparam int RED_P = TIME_BITS + RED_OFS;
    localparam int GRN_P = TIME_BITS + GRN_OFS;
    localparam int BLU_P = TIME_BITS + BLU_OFS;
    localparam int INT_P = TIME_BITS + INT_OFS;

    localparam logic [CFG_IDX_W-1:0] LAST_CFG = CFG_IDX_W'(MAX_KEYS);
    localparam logic [IDX_W-1:0]     N_MAX    = IDX_W'(MAX_KEYS);
    localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(TIME_BITS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    // Configuration registers.
    logic [KEY_COUNT_W-1:0] r_key_count;
    logic [KW-1:0]          r_key [MAX_KEYS];

    // Sequencer.
    logic [2:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_n, n_n;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_is_key, n_is_key;
    logic [TIME_BITS-1:0]   r_t, n_t;
    logic [KW-1:0]          r_prev, n_prev;
    logic [TIME_BITS:0]     r_u, n_u;

    // Output register.
    logic                   r_out_valid;
    logic [COLOR_W-1:0]     r_red, r_grn, r_blu;
    logic [INTEN_W-1:0]     r_int;

    logic                   w_accept;
    logic                   w_out_free;
    logic [KW-1:0]          w_cur;
    logic [TIME_BITS:0]     w_t_ext;
    logic [TIME_BITS:0]     w_s;
    logic [TIME_BITS:0]     w_e;
    logic                   w_match;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [TIME_BITS:0]     w_quot;
    logic [CFG_IDX_W-1:0]   w_widx;
    logic [IDX_W-1:0]       w_n_eff;
    t_lerp_ctl              w_ctl;
    logic [COLOR_W-1:0]     w_lred, w_lgrn, w_lblu;
    logic [INTEN_W-1:0]     w_lint;
    logic [COLOR_W-1:0]     w_red, w_grn, w_blu;
    logic [INTEN_W-1:0]     w_int;

    // Configuration is always taken; writes beyond the last keyframe are dropped.
    assign o_cfg_ready = 1'b1;
    assign w_widx      = i_cfg_index - CFG_KEY_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_W'(1);
            for (int k = 0; k < MAX_KEYS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_KEY_COUNT) begin
                r_key_count <= i_cfg_data[KEY_COUNT_W-1:0];
            end else if (i_cfg_index <= LAST_CFG) begin
                r_key[w_widx[KA_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // A count of zero means one keyframe; counts above the store saturate.
    always_comb begin
        if (r_key_count == '0) begin
            w_n_eff = IDX_W'(1);
        end else if (r_key_count > KEY_COUNT_W'(MAX_KEYS)) begin
            w_n_eff = N_MAX;
        end else begin
            w_n_eff = IDX_W'(r_key_count);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // The scan walks the keyframes one per cycle; r_prev holds the one before.
    assign w_cur   = (r_idx < N_MAX) ? r_key[r_idx[KA_W-1:0]] : '0;
    assign w_t_ext = {1'b0, r_t};
    assign w_s     = r_prev[TIME_BITS:0];
    assign w_e     = w_cur[TIME_BITS:0];
    assign w_match = (w_t_ext >= w_s) && (w_t_ext <= w_e);

    assign w_div_start = (r_state == ST_SCAN) && (r_idx != r_n) && w_match;

    kci_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_t_ext - w_s),
        .i_den   (w_e - w_s),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // The fraction leaves r_u least significant bit first into the blend units.
    always_comb begin
        w_ctl.load = w_div_start;
        w_ctl.step = (r_state == ST_MUL);
        w_ctl.last = (r_cnt == CNT_LAST);
        w_ctl.ubit = r_u[0];
    end

    kci_lerp #(.W(COLOR_W)) u_lerp_red (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (r_prev[RED_P+COLOR_W-1:RED_P]),
        .i_b   (w_cur[RED_P+COLOR_W-1:RED_P]),
        .o_val (w_lred)
    );

    kci_lerp #(.W(COLOR_W)) u_lerp_grn (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (r_prev[GRN_P+COLOR_W-1:GRN_P]),
        .i_b   (w_cur[GRN_P+COLOR_W-1:GRN_P]),
        .o_val (w_lgrn)
    );

    kci_lerp #(.W(COLOR_W)) u_lerp_blu (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (r_prev[BLU_P+COLOR_W-1:BLU_P]),
        .i_b   (w_cur[BLU_P+COLOR_W-1:BLU_P]),
        .o_val (w_lblu)
    );

    kci_lerp #(.W(INTEN_W)) u_lerp_int (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (r_prev[INT_P+INTEN_W-1:INT_P]),
        .i_b   (w_cur[INT_P+INTEN_W-1:INT_P]),
        .o_val (w_lint)
    );

    // Sequencer next state.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_n      = r_n;
        n_cnt    = r_cnt;
        n_is_key = r_is_key;
        n_t      = r_t;
        n_prev   = r_prev;
        n_u      = r_u;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_t     = s_axis_tdata[TIME_BITS-1:0];
                    n_n     = w_n_eff;
                    n_prev  = r_key[0];
                    n_idx   = IDX_W'(1);
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_n) begin
                    // No pair enclosed the time: r_prev is the last keyframe.
                    n_is_key = 1'b1;
                    n_state  = ST_FIN;
                end else if (w_match) begin
                    n_is_key = 1'b0;
                    n_state  = ST_DIV;
                end else begin
                    n_prev = w_cur;
                    n_idx  = r_idx + IDX_W'(1);
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_u     = w_quot;
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_u   = r_u >> 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_cnt    <= n_cnt;
        r_is_key <= n_is_key;
        r_t      <= n_t;
        r_prev   <= n_prev;
        r_u      <= n_u;
    end

    // Result selection: a keyframe copied as is, or the blended values.
    assign w_red = r_is_key ? r_prev[RED_P+COLOR_W-1:RED_P] : w_lred;
    assign w_grn = r_is_key ? r_prev[GRN_P+COLOR_W-1:GRN_P] : w_lgrn;
    assign w_blu = r_is_key ? r_prev[BLU_P+COLOR_W-1:BLU_P] : w_lblu;
    assign w_int = r_is_key ? r_prev[INT_P+INTEN_W-1:INT_P] : w_lint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_red <= w_red;
            r_grn <= w_grn;
            r_blu <= w_blu;
            r_int <= w_int;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_int, r_blu, r_grn, r_red};

`ifndef SYNTHESIS
    // An accepted item always starts the keyframe scan.
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN))
        else $error("accepted item did not start the scan");

    // A finished item that finds the output free is presented the next cycle.
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && w_out_free |=> m_axis_tvalid && (r_state == ST_IDLE))
        else $error("finished item was not presented");

    // The blend never runs past the integer bit of the fraction.
    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_cnt <= CNT_LAST))
        else $error("blend step count overran");

    // The divider reports done only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");
`endif

endmodule
